[src/jbw_pkg.sv]
// Shared types and constants of the JPEG bit writer.
package jbw_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_CODE   = 2'd0;
   localparam logic [1:0] KIND_ALIGN  = 2'd1;
   localparam logic [1:0] KIND_MARKER = 2'd2;
   localparam logic [1:0] KIND_WORD   = 2'd3;

   // Default sizes.
   localparam int ACC_BITS_DEFAULT    = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Longest code that one request may append.
   localparam logic [4:0] MAX_CODE_LEN = 5'd16;

   // Byte that is followed by a stuffed zero, and the marker prefix.
   localparam logic [7:0] FF_BYTE = 8'hFF;

   // One or two bytes produced by a request, with their stuffing flags.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       stuff0;
      logic       stuff1;
      logic       two;
   } job_type;

endpackage

[src/jbw_front.sv]
// Front part: bit packing of code and align requests, byte pairs of markers and words.
module jbw_front #(
   parameter int ACC_BITS = jbw_pkg::ACC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [1:0]       kind,
   input  logic [15:0]      value,
   input  logic [4:0]       code_length,
   output logic             job_push,
   output jbw_pkg::job_type job
);

   logic [ACC_BITS-1:0] acc_ff, acc_in;
   logic [2:0]          pend_ff, pend_in;

   logic        is_bits;
   logic [4:0]  n_eff;
   logic [15:0] w_raw, w_mask, w_left;
   logic [16:0] mask_wide;
   logic [23:0] win, shifted;
   logic [4:0]  total;
   logic [1:0]  nbytes;
   logic [7:0]  remain;

   // Select the bits to append: the code itself or ones up to the byte boundary.
   always_comb begin
      is_bits = (kind == jbw_pkg::KIND_CODE) || (kind == jbw_pkg::KIND_ALIGN);
      if (kind == jbw_pkg::KIND_CODE) begin
         n_eff = (code_length > jbw_pkg::MAX_CODE_LEN) ? jbw_pkg::MAX_CODE_LEN : code_length;
         w_raw = value;
      end else if (pend_ff == 3'd0) begin
         n_eff = 5'd0;
         w_raw = 16'hFFFF;
      end else begin
         n_eff = 5'd8 - {2'b00, pend_ff};
         w_raw = 16'hFFFF;
      end
   end

   // Place the new bits right behind the pending bits in a 24-bit window.
   always_comb begin
      mask_wide = (17'h1 << n_eff) - 17'h1;
      w_mask    = w_raw & mask_wide[15:0];
      w_left    = w_mask << (5'd16 - n_eff);
      win       = {acc_ff[ACC_BITS-1 -: 8], 16'h0000} | ({w_left, 8'h00} >> pend_ff);
      total     = {2'b00, pend_ff} + n_eff;
      if (total[4]) begin
         nbytes = 2'd2;
      end else if (total[3]) begin
         nbytes = 2'd1;
      end else begin
         nbytes = 2'd0;
      end
      shifted = win << {nbytes, 3'b000};
      remain  = shifted[23:16];
   end

   // Build the job for the queue.
   always_comb begin
      job = '0;
      if (is_bits) begin
         job.byte0  = win[23:16];
         job.byte1  = win[15:8];
         job.stuff0 = (win[23:16] == jbw_pkg::FF_BYTE);
         job.stuff1 = (win[15:8] == jbw_pkg::FF_BYTE);
         job.two    = nbytes[1];
         job_push   = accept && (nbytes != 2'd0);
      end else begin
         job.byte0  = (kind == jbw_pkg::KIND_MARKER) ? jbw_pkg::FF_BYTE : value[15:8];
         job.byte1  = value[7:0];
         job.stuff0 = 1'b0;
         job.stuff1 = 1'b0;
         job.two    = 1'b1;
         job_push   = accept;
      end
   end

   // Pending bits are updated by code and align requests only.
   always_comb begin
      acc_in  = acc_ff;
      pend_in = pend_ff;
      if (accept && is_bits) begin
         acc_in  = {remain, {(ACC_BITS-8){1'b0}}};
         pend_in = total[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

endmodule

[src/jbw_queue.sv]
// Short job queue between the front and back parts.
module jbw_queue #(
   parameter int DEPTH = jbw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jbw_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output jbw_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   jbw_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == FULL_CNT);
   assign not_empty = (cnt_ff != '0);
   assign head_job  = entry_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointer and fill count update.
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

endmodule

[src/jbw_back.sv]
// Back part: sends job bytes one per cycle unless stalled, adding stuffed zeros.
module jbw_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  jbw_pkg::job_type job,
   output logic             job_pop,
   output logic             out_valid,
   output logic [7:0]       out_byte,
   output logic             out_last,
   input  logic             out_pop
);

   // Position within a job.
   localparam logic [1:0] STEP_BYTE0  = 2'd0;
   localparam logic [1:0] STEP_STUFF0 = 2'd1;
   localparam logic [1:0] STEP_BYTE1  = 2'd2;
   localparam logic [1:0] STEP_STUFF1 = 2'd3;

   logic [1:0] step_ff, step_in, step_next;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       can_load, send, done;
   logic [7:0] cur_byte;

   assign can_load = !valid_ff || out_pop;
   assign send     = job_valid && can_load;

   // Byte of the current step and the step after it.
   always_comb begin
      unique case (step_ff)
         STEP_BYTE0: begin
            cur_byte  = job.byte0;
            done      = !job.stuff0 && !job.two;
            step_next = job.stuff0 ? STEP_STUFF0 : STEP_BYTE1;
         end
         STEP_STUFF0: begin
            cur_byte  = 8'h00;
            done      = !job.two;
            step_next = STEP_BYTE1;
         end
         STEP_BYTE1: begin
            cur_byte  = job.byte1;
            done      = !job.stuff1;
            step_next = STEP_STUFF1;
         end
         STEP_STUFF1: begin
            cur_byte  = 8'h00;
            done      = 1'b1;
            step_next = STEP_BYTE0;
         end
         default: begin
            cur_byte  = 8'h00;
            done      = 1'b1;
            step_next = STEP_BYTE0;
         end
      endcase
   end

   assign job_pop = send && done;

   // Output register and step update.
   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (can_load) begin
         valid_in = send;
      end
      if (send) begin
         byte_in = cur_byte;
         last_in = done;
         step_in = done ? STEP_BYTE0 : step_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_BYTE0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

[src/jpeg_bit_writer_with_stuffing.sv]
// Top level of the JPEG entropy bit writer with byte stuffing.
//
// A request is taken every cycle while full is low. Code and align requests are packed
// into the pending bits at once and their complete bytes, each 0xFF flagged for a 0x00 after
// it, go into a short job queue together with the two bytes of marker and word requests. The
// back part sends one byte per cycle on the response side while the output is popped, and a
// request produces zero to four bytes (usually one or two); a request that completes no byte
// produces no response. The single output byte port sets the sustained rate; the queue of
// QUEUE_DEPTH jobs absorbs bursts, and full rises only when it is full. rsp_last marks
// the final byte of each request.
module jpeg_bit_writer_with_stuffing #(
   parameter int ACC_BITS    = jbw_pkg::ACC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = jbw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_kind,
   input  logic [15:0] req_value,
   input  logic [4:0]  req_code_length,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   jbw_pkg::job_type front_job, head_job;
   logic             accept, job_push, job_pop, head_valid, out_valid;

   assign accept = push && !full;

   // Front part: packing and classification.
   jbw_front #(
      .ACC_BITS(ACC_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .kind        (req_kind),
      .value       (req_value),
      .code_length (req_code_length),
      .job_push    (job_push),
      .job         (front_job)
   );

   // Job queue.
   jbw_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (front_job),
      .full      (full),
      .pop       (job_pop),
      .not_empty (head_valid),
      .head_job  (head_job)
   );

   // Back part: byte sequencing and stuffing.
   jbw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .out_valid (out_valid),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_last),
      .out_pop   (pop)
   );

   assign empty = !out_valid;

endmodule
